FILE: sv/tife_pkg.sv
// Shared types, constants and frame helpers for the tape image frame encoder.
// No dependencies; imported by every module of the block.
package tife_pkg;

  localparam int HEADER_BYTES = 9;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int FRAME_W = 14;
  localparam int REP_W   = 10;
  localparam int SAMP_W  = 16;
  localparam int BCNT_W  = 17;
  localparam int DLEN_W  = 18;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAP_W      = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h16;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h24;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd2;

  localparam logic [SAMP_W-1:0] PAUSE_RST  = 16'd1200;
  localparam logic [REP_W-1:0]  LEADER_RST = 10'd512;
  localparam logic [GAP_W-1:0]  GAP_RST    = 8'd100;

  // samples of one 0x16 frame: 7 ones, 7 zeros
  localparam logic [SAMP_W-1:0] LEADER_FRAME_SAMPLES = 16'd35;

  typedef enum logic [KIND_W-1:0] {
    SEG_PAUSE = 2'd0,
    SEG_FRAME = 2'd1,
    SEG_RUN   = 2'd2
  } seg_kind_e;

  typedef enum logic [1:0] {
    ACT_FRAME        = 2'd0,
    ACT_LEADER       = 2'd1,
    ACT_LEADER_START = 2'd2,
    ACT_FRAME_GAP    = 2'd3
  } act_e;

  typedef struct packed {
    act_e              act;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [SAMP_W-1:0] pause_samples;
    logic [REP_W-1:0]  leader_count;
    logic [GAP_W-1:0]  gap_ones;
  } cfg_t;

  function automatic logic [FRAME_W-1:0] make_frame(input logic [BYTE_W-1:0] b);
    logic par;
    par = ~(^b);
    return {4'hF, par, b, 1'b0};
  endfunction

  function automatic logic [SAMP_W-1:0] frame_samples(input logic [FRAME_W-1:0] f);
    logic [SAMP_W-1:0] n;
    n = SAMP_W'(3 * FRAME_W);
    for (int i = 0; i < FRAME_W; i++) begin
      n = n - SAMP_W'(f[i]);
    end
    return n;
  endfunction

endpackage

FILE: sv/tife_front.sv
// Front end: accepts tape bytes, runs the parser modes and issues segment commands.
// Depends on tife_pkg.
module tife_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [tife_pkg::BYTE_W-1:0] byte_value_i,
  input  logic                   q_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output tife_pkg::cmd_t         cmd_o
);
  import tife_pkg::*;

  typedef enum logic [4:0] {
    MODE_SEARCH = 5'b00001,
    MODE_SYNC   = 5'b00010,
    MODE_HEADER = 5'b00100,
    MODE_NAME   = 5'b01000,
    MODE_DATA   = 5'b10000
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [DLEN_W-1:0]  dlen_q, dlen_d;
  logic [BYTE_W-1:0]  hdr_q [4];
  logic               hdr_we;
  logic               accept;
  logic [BCNT_W-1:0]  bcnt_inc;
  logic               bcnt_hit;
  logic               dlen_pos;
  logic [15:0]        end_addr, start_addr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign bcnt_inc   = bcnt_q + BCNT_W'(1);
  assign bcnt_hit   = ({1'b0, bcnt_inc} == dlen_q);
  assign dlen_pos   = !dlen_q[DLEN_W-1] && (dlen_q != '0);
  assign end_addr   = {hdr_q[0], hdr_q[1]};
  assign start_addr = {hdr_q[2], hdr_q[3]};

  always_comb begin
    mode_d     = mode_q;
    bcnt_d     = bcnt_q;
    dlen_d     = dlen_q;
    hdr_we     = 1'b0;
    push_o     = 1'b0;
    cmd_o.act  = ACT_FRAME;
    cmd_o.data = byte_value_i;
    unique case (mode_q)
      MODE_SYNC: begin
        if (byte_value_i != SYNC_BYTE) begin
          push_o    = accept;
          cmd_o.act = ACT_LEADER;
          if (byte_value_i == START_BYTE) begin
            cmd_o.act = ACT_LEADER_START;
            mode_d    = MODE_HEADER;
            bcnt_d    = '0;
            dlen_d    = DLEN_W'(HEADER_BYTES);
          end
        end
      end
      MODE_HEADER: begin
        push_o = accept;
        hdr_we = (bcnt_q >= BCNT_W'(4)) && (bcnt_q < BCNT_W'(8));
        bcnt_d = bcnt_inc;
        if (bcnt_hit) begin
          mode_d = MODE_NAME;
        end
      end
      MODE_NAME: begin
        push_o = accept;
        if (byte_value_i == '0) begin
          cmd_o.act = ACT_FRAME_GAP;
          mode_d    = MODE_DATA;
          bcnt_d    = '0;
          dlen_d    = {2'b00, end_addr} - {2'b00, start_addr} + DLEN_W'(1);
        end
      end
      MODE_DATA: begin
        push_o = accept;
        bcnt_d = bcnt_inc;
        if (dlen_pos && bcnt_hit) begin
          mode_d = MODE_SEARCH;
        end
      end
      default: begin
        mode_d = (byte_value_i == SYNC_BYTE) ? MODE_SYNC : MODE_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      bcnt_q <= '0;
      dlen_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      bcnt_q <= bcnt_d;
      dlen_q <= dlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hdr_we) begin
      hdr_q[bcnt_q[1:0]] <= byte_value_i;
    end
  end

endmodule

FILE: sv/tife_queue.sv
// Short command queue between the parser front end and the segment back end.
// Depends on tife_pkg.
module tife_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tife_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tife_pkg::cmd_t rdata_o
);
  import tife_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/tife_back.sv
// Back end: expands one queued command into its segments through an output register.
// Depends on tife_pkg.
module tife_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tife_pkg::cfg_t                cfg_i,
  input  logic                          q_valid_i,
  input  tife_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tife_pkg::KIND_W-1:0]   seg_kind_o,
  output logic [tife_pkg::FRAME_W-1:0]  frame_bits_o,
  output logic [tife_pkg::REP_W-1:0]    repeat_res_o,
  output logic [tife_pkg::SAMP_W-1:0]   seg_samples_o,
  output logic                          last_o
);
  import tife_pkg::*;

  cmd_t               cur_q;
  logic               cur_v_q;
  logic [1:0]         idx_q;
  logic               adv;
  logic               out_v_q;

  seg_kind_e          kind_d;
  logic [FRAME_W-1:0] frame_d;
  logic [REP_W-1:0]   rep_d;
  logic [SAMP_W-1:0]  samp_d;
  logic               last_d;

  logic [FRAME_W-1:0] cur_frame;
  logic [FRAME_W-1:0] lead_frame;
  logic [SAMP_W-1:0]  lead_samp;

  assign cur_frame  = make_frame(cur_q.data);
  assign lead_frame = make_frame(SYNC_BYTE);
  assign lead_samp  = SAMP_W'({{(SAMP_W-REP_W){1'b0}}, cfg_i.leader_count}
                              * LEADER_FRAME_SAMPLES);

  assign adv   = cur_v_q && (!out_v_q || !out_stall_i);
  assign pop_o = q_valid_i && (!cur_v_q || (adv && last_d));

  always_comb begin
    kind_d  = SEG_FRAME;
    frame_d = cur_frame;
    rep_d   = REP_W'(1);
    samp_d  = frame_samples(cur_frame);
    last_d  = 1'b1;
    if ((cur_q.act == ACT_LEADER || cur_q.act == ACT_LEADER_START) && idx_q == 2'd0) begin
      kind_d  = SEG_PAUSE;
      frame_d = '0;
      rep_d   = '0;
      samp_d  = cfg_i.pause_samples;
      last_d  = 1'b0;
    end else if ((cur_q.act == ACT_LEADER || cur_q.act == ACT_LEADER_START)
                 && idx_q == 2'd1) begin
      frame_d = lead_frame;
      rep_d   = cfg_i.leader_count;
      samp_d  = lead_samp;
      last_d  = (cur_q.act == ACT_LEADER);
    end else if (cur_q.act == ACT_FRAME_GAP && idx_q == 2'd1) begin
      kind_d  = SEG_RUN;
      frame_d = '0;
      rep_d   = {{(REP_W-GAP_W){1'b0}}, cfg_i.gap_ones};
      samp_d  = {{(SAMP_W-GAP_W-1){1'b0}}, cfg_i.gap_ones, 1'b0};
    end else if (cur_q.act == ACT_FRAME_GAP) begin
      last_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_v_q <= 1'b1;
        idx_q   <= '0;
      end else if (adv && last_d) begin
        cur_v_q <= 1'b0;
        idx_q   <= '0;
      end else if (adv) begin
        idx_q <= idx_q + 2'd1;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (adv) begin
      seg_kind_o    <= kind_d;
      frame_bits_o  <= frame_d;
      repeat_res_o  <= rep_d;
      seg_samples_o <= samp_d;
      last_o        <= last_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

FILE: sv/tape_image_frame_encoder_top.sv
// Top level of the tape image frame encoder: config registers, front end, queue, back end.
// Depends on tife_pkg, tife_front, tife_queue, tife_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  in      | in        | in_valid_i / in_stall_o  | byte_value_i
//  out     | out       | out_valid_o / out_stall_i| seg_kind_o frame_bits_o repeat_res_o
//          |           |                          | seg_samples_o last_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
// The front end takes one byte per cycle while the two-entry command queue has room.
// The back end emits one segment per cycle unless out_stall_i holds it; a byte yields
// up to three segments (pause, leader, start frame); the back end sets the sustained rate.
// Reset is asynchronous, active low; no clearing pass. The cfg port is always ready.
// Output stall holds the output register; the queue absorbs input meanwhile.
module tape_image_frame_encoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tife_pkg::BYTE_W-1:0]       byte_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tife_pkg::KIND_W-1:0]       seg_kind_o,
  output logic [tife_pkg::FRAME_W-1:0]      frame_bits_o,
  output logic [tife_pkg::REP_W-1:0]        repeat_res_o,
  output logic [tife_pkg::SAMP_W-1:0]       seg_samples_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tife_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tife_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import tife_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pause_samples <= PAUSE_RST;
      cfg_q.leader_count  <= LEADER_RST;
      cfg_q.gap_ones      <= GAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PAUSE:  cfg_q.pause_samples <= cfg_data_i;
        CFG_LEADER: cfg_q.leader_count  <= cfg_data_i[REP_W-1:0];
        CFG_GAP:    cfg_q.gap_ones      <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  tife_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .byte_value_i (byte_value_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (q_push),
    .cmd_o        (push_cmd)
  );

  tife_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (pop_cmd)
  );

  tife_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .seg_kind_o    (seg_kind_o),
    .frame_bits_o  (frame_bits_o),
    .repeat_res_o  (repeat_res_o),
    .seg_samples_o (seg_samples_o),
    .last_o        (last_o)
  );

  // start and stop bits on every frame; samples only on single frames, as the leader spans repeat_res_o frames
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seg_kind_o == SEG_FRAME |->
      frame_bits_o[0] == 1'b0 && frame_bits_o[13:10] == 4'hF &&
      (repeat_res_o != REP_W'(1) ||
       seg_samples_o == SAMP_W'(3 * FRAME_W) - SAMP_W'($countones(frame_bits_o))))
    else $error("byte frame malformed");

  a_pause_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seg_kind_o == SEG_PAUSE |->
      frame_bits_o == '0 && repeat_res_o == '0 && !last_o)
    else $error("pause segment malformed");

  a_run_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seg_kind_o == SEG_RUN |->
      seg_samples_o == {5'b0, repeat_res_o, 1'b0} && last_o)
    else $error("run segment malformed");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command queue overflow");

endmodule

FILE: tb/sv/tape_image_frame_encoder_top_tb.sv
// Self-checking testbench for tape_image_frame_encoder_top: tape records in, segments checked
// against a behavioral parser model. Depends on tife_pkg and the encoder RTL.
module tape_image_frame_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tife_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 120;

  typedef enum logic [2:0] {
    MODE_SEARCH,
    MODE_SYNC,
    MODE_HEADER,
    MODE_NAME,
    MODE_DATA
  } parse_mode_e;

  typedef struct packed {
    seg_kind_e          kind;
    logic [FRAME_W-1:0] frame;
    logic [REP_W-1:0]   rep;
    logic [SAMP_W-1:0]  samples;
    logic               last;
  } seg_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     byte_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [KIND_W-1:0]     seg_kind_o;
  logic [FRAME_W-1:0]    frame_bits_o;
  logic [REP_W-1:0]      repeat_res_o;
  logic [SAMP_W-1:0]     seg_samples_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tape_image_frame_encoder_top dut (.*);

  // stimulus bookkeeping
  logic [BYTE_W-1:0] to_send[$];
  seg_t              exp_segs[$];
  int                bytes_queued = 0;
  int                bytes_accepted = 0;
  int                err_cnt = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              hold_req = 1'b0;
  logic              hold_done = 1'b0;
  int                hold_left = 0;

  // parser model state
  logic [SAMP_W-1:0] cfg_pause = PAUSE_RST;
  logic [REP_W-1:0]  cfg_leader = LEADER_RST;
  logic [GAP_W-1:0]  cfg_gap = GAP_RST;
  parse_mode_e       parse_mode = MODE_SEARCH;
  logic [BCNT_W-1:0] pos_cnt = '0;
  int                data_len = 0;
  logic [BYTE_W-1:0] addr_bytes [4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [FRAME_W-1:0] frame_of(input logic [BYTE_W-1:0] b);
    return {4'hF, ~(^b), b, 1'b0};
  endfunction

  // ones take 2 samples, zeros 3
  function automatic logic [SAMP_W-1:0] samples_of(input logic [FRAME_W-1:0] f);
    return SAMP_W'(3 * FRAME_W - $countones(f));
  endfunction

  function automatic seg_t byte_frame(input logic [BYTE_W-1:0] b);
    return '{kind: SEG_FRAME, frame: frame_of(b), rep: REP_W'(1),
             samples: samples_of(frame_of(b)), last: 1'b0};
  endfunction

  function automatic void predict_segments(input logic [BYTE_W-1:0] b);
    seg_t             segs[$];
    logic [15:0]      end_addr;
    logic [15:0]      start_addr;
    case (parse_mode)
      MODE_SYNC: begin
        if (b != SYNC_BYTE) begin
          segs.push_back('{kind: SEG_PAUSE, frame: '0, rep: '0, samples: cfg_pause,
                           last: 1'b0});
          segs.push_back('{kind: SEG_FRAME, frame: frame_of(SYNC_BYTE), rep: cfg_leader,
                           samples: SAMP_W'(cfg_leader * samples_of(frame_of(SYNC_BYTE))),
                           last: 1'b0});
          if (b == START_BYTE) begin
            segs.push_back(byte_frame(b));
            parse_mode = MODE_HEADER;
            pos_cnt = '0;
            data_len = HEADER_BYTES;
          end
        end
      end
      MODE_HEADER: begin
        if (pos_cnt >= 4 && pos_cnt < 8) addr_bytes[pos_cnt - 4] = b;
        segs.push_back(byte_frame(b));
        pos_cnt = pos_cnt + 1'b1;
        if (int'(pos_cnt) == data_len) parse_mode = MODE_NAME;
      end
      MODE_NAME: begin
        segs.push_back(byte_frame(b));
        if (b == 8'h00) begin
          end_addr = {addr_bytes[0], addr_bytes[1]};
          start_addr = {addr_bytes[2], addr_bytes[3]};
          segs.push_back('{kind: SEG_RUN, frame: '0, rep: REP_W'(cfg_gap),
                           samples: SAMP_W'(cfg_gap) * SAMP_W'(2), last: 1'b0});
          parse_mode = MODE_DATA;
          pos_cnt = '0;
          data_len = int'(end_addr) - int'(start_addr) + 1;
        end
      end
      MODE_DATA: begin
        segs.push_back(byte_frame(b));
        pos_cnt = pos_cnt + 1'b1;
        if (data_len > 0 && int'(pos_cnt) == data_len) parse_mode = MODE_SEARCH;
      end
      default: begin
        if (b == SYNC_BYTE) parse_mode = MODE_SYNC;
        else parse_mode = MODE_SEARCH;
      end
    endcase
    if (segs.size() != 0) segs[segs.size() - 1].last = 1'b1;
    foreach (segs[i]) exp_segs.push_back(segs[i]);
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_segments(byte_value_i);
        bytes_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          byte_value_i <= to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall generator, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin : seg_monitor
    seg_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_segs.size() == 0) begin
        $error("unexpected segment: kind %0d frame %h rep %0d samples %0d last %0b",
               seg_kind_o, frame_bits_o, repeat_res_o, seg_samples_o, last_o);
        err_cnt++;
      end else begin
        want = exp_segs.pop_front();
        if (seg_kind_o !== want.kind) begin
          $error("seg_kind: expected %0d, got %0d", want.kind, seg_kind_o);
          err_cnt++;
        end
        if (frame_bits_o !== want.frame) begin
          $error("frame_bits: expected %h, got %h", want.frame, frame_bits_o);
          err_cnt++;
        end
        if (repeat_res_o !== want.rep) begin
          $error("repeat_res: expected %0d, got %0d", want.rep, repeat_res_o);
          err_cnt++;
        end
        if (seg_samples_o !== want.samples) begin
          $error("seg_samples: expected %0d, got %0d", want.samples, seg_samples_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    to_send.push_back(b);
    bytes_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PAUSE:  cfg_pause = data;
      CFG_LEADER: cfg_leader = data[REP_W-1:0];
      CFG_GAP:    cfg_gap = data[GAP_W-1:0];
      default:    ;
    endcase
  endtask

  task automatic drain_segments();
    while (bytes_accepted != bytes_queued) @(posedge clk_i);
    while (exp_segs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // start byte, header with addresses, name, terminator, data
  task automatic queue_tape_record(input logic [15:0] start_addr, input logic [15:0] end_addr,
                                   input int data_bytes);
    queue_byte(START_BYTE);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      case (i)
        4:       queue_byte(end_addr[15:8]);
        5:       queue_byte(end_addr[7:0]);
        6:       queue_byte(start_addr[15:8]);
        7:       queue_byte(start_addr[7:0]);
        default: queue_byte(BYTE_W'($urandom));
      endcase
    end
    repeat ($urandom_range(0, 4)) queue_byte(BYTE_W'($urandom_range(1, 255)));
    queue_byte(8'h00);
    repeat (data_bytes) queue_byte(BYTE_W'($urandom));
  endtask

  task automatic queue_random_record();
    int                len;
    logic [15:0]       start_addr;
    logic [BYTE_W-1:0] b;
    repeat ($urandom_range(0, 2)) begin
      do b = BYTE_W'($urandom); while (b == SYNC_BYTE);
      queue_byte(b);
    end
    repeat ($urandom_range(1, 3)) queue_byte(SYNC_BYTE);
    // broken leader: stray bytes between the sync run and the start byte
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
      do b = BYTE_W'($urandom); while (b == SYNC_BYTE || b == START_BYTE);
      queue_byte(b);
    end
    case ($urandom_range(0, 9))
      0: begin
        len = $urandom_range(9, 40);
        start_addr = 16'($urandom_range(0, 65536 - len));
      end
      1: begin
        len = $urandom_range(1, 4);
        start_addr = 16'(65536 - len);
      end
      2: begin
        len = $urandom_range(1, 4);
        start_addr = 16'h0000;
      end
      default: begin
        len = $urandom_range(1, 8);
        start_addr = 16'($urandom_range(0, 65536 - len));
      end
    endcase
    queue_tape_record(start_addr, 16'(start_addr + len - 1), len);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] directed_bytes [19] = '{
      8'h00, 8'hFF, 8'h16, 8'h16, 8'hFF, 8'h24,
      8'h00, 8'hFF, 8'hAA, 8'h55, 8'h12, 8'h35, 8'h12, 8'h34, 8'hFF,
      8'hFF, 8'h00,
      8'h00, 8'hFF};
    int          phase_base;
    logic [15:0] start_addr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct <= 12;
    recv_stall_pct <= 76;
    write_reg(CFG_PAUSE, 16'd0);
    write_reg(CFG_LEADER, 16'd1);
    write_reg(CFG_GAP, 16'd0);
    write_reg(CFG_SPARE, 16'($urandom));
    foreach (directed_bytes[i]) queue_byte(directed_bytes[i]);
    drain_segments();

    for (int phase = 1; phase <= 3; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_PAUSE, 16'hFFFF);
          write_reg(CFG_LEADER, 16'd1023);
          write_reg(CFG_GAP, 16'd255);
        end
        2: begin
          send_idle_pct <= 76;
          recv_stall_pct <= 12;
          write_reg(CFG_PAUSE, 16'($urandom));
          write_reg(CFG_LEADER, 16'($urandom_range(1, 1023)));
          write_reg(CFG_GAP, 16'($urandom_range(0, 255)));
        end
        default: begin
          send_idle_pct <= 0;
          recv_stall_pct <= 0;
          write_reg(CFG_PAUSE, 16'($urandom));
          write_reg(CFG_LEADER, {6'($urandom), 10'($urandom_range(1, 1023))});
          write_reg(CFG_GAP, 16'($urandom));
          write_reg(CFG_SPARE, 16'($urandom));
        end
      endcase
      phase_base = bytes_queued;
      while (bytes_queued - phase_base < PHASE_ITEMS) queue_random_record();
      if (phase == 3) begin
        hold_req <= 1'b1;
        // record whose length is zero or negative: data mode never ends
        if ($urandom_range(0, 1) == 0) begin
          start_addr = 16'($urandom_range(1, 65535));
          queue_tape_record(start_addr, start_addr - 16'd1, 30);
        end else begin
          queue_tape_record(16'hFFFF, 16'h0000, 30);
        end
      end
      drain_segments();
    end

    if (err_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/tife_pkg.sv
sv/tife_front.sv
sv/tife_queue.sv
sv/tife_back.sv
sv/tape_image_frame_encoder_top.sv
tb/sv/tape_image_frame_encoder_top_tb.sv
